[hw/rtl/tone_sequence_player_macros.svh]
// ---------------------------------------------------------------------------
// Tone sequence player assertion macros
// Clocked concurrent assertion helpers shared by the player RTL.
// ---------------------------------------------------------------------------
`ifndef TONE_SEQUENCE_PLAYER_MACROS_SVH
`define TONE_SEQUENCE_PLAYER_MACROS_SVH

// General form with explicit clock and reset.
`define TSP_ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Short form for the player's own clock and reset.
`define TSP_ASSERT(label, prop, msg) \
  `TSP_ASSERT_CLK(label, clk, rst, prop, msg)

`endif

[hw/rtl/tsp_pkg.sv]
// ---------------------------------------------------------------------------
// Tone sequence player package
// Constants, codes and the default melody shared by the player and its
// channel interfaces.
// ---------------------------------------------------------------------------
package tsp_pkg;

  localparam int CLOCK_HZ      = 20000000;
  localparam int TONE_SLOTS    = 32;
  localparam int SLOT_W        = 5;
  localparam int LEN_W         = 6;
  localparam int HALF_W        = 25;
  localparam int DEFAULT_COUNT = 30;

  localparam logic [31:0] TICKS_RESET = 32'd2000000;
  localparam logic [HALF_W-1:0] CLK_DIVIDEND = HALF_W'(CLOCK_HZ);

  typedef logic [1:0] action_t;
  typedef logic [1:0] err_t;
  typedef logic [HALF_W-1:0] half_t;

  localparam action_t ACT_TICK  = 2'd0;
  localparam action_t ACT_WRITE = 2'd1;
  localparam action_t ACT_PLAY  = 2'd2;
  localparam action_t ACT_STOP  = 2'd3;

  localparam err_t ERR_NONE = 2'd0;
  localparam err_t ERR_SLOT = 2'd1;
  localparam err_t ERR_FREQ = 2'd2;

  // Half-periods of the default melody, in clock ticks; unused slots hold zero.
  localparam half_t DEFAULT_HALF [TONE_SLOTS] = '{
    HALF_W'(CLOCK_HZ / (2 * 900)),   HALF_W'(CLOCK_HZ / (2 * 2500)),
    HALF_W'(CLOCK_HZ / (2 * 450)),   HALF_W'(CLOCK_HZ / (2 * 12000)),
    HALF_W'(CLOCK_HZ / (2 * 500)),   HALF_W'(CLOCK_HZ / (2 * 2500)),
    HALF_W'(CLOCK_HZ / (2 * 250)),   HALF_W'(CLOCK_HZ / (2 * 5500)),
    HALF_W'(CLOCK_HZ / (2 * 1050)),  HALF_W'(CLOCK_HZ / (2 * 2450)),
    HALF_W'(CLOCK_HZ / (2 * 230)),   HALF_W'(CLOCK_HZ / (2 * 7000)),
    HALF_W'(CLOCK_HZ / (2 * 900)),   HALF_W'(CLOCK_HZ / (2 * 2500)),
    HALF_W'(CLOCK_HZ / (2 * 450)),   HALF_W'(CLOCK_HZ / (2 * 14000)),
    HALF_W'(CLOCK_HZ / (2 * 1200)),  HALF_W'(CLOCK_HZ / (2 * 120)),
    HALF_W'(CLOCK_HZ / (2 * 1150)),  HALF_W'(CLOCK_HZ / (2 * 8500)),
    HALF_W'(CLOCK_HZ / (2 * 5050)),  HALF_W'(CLOCK_HZ / (2 * 2450)),
    HALF_W'(CLOCK_HZ / (2 * 3430)),  HALF_W'(CLOCK_HZ / (2 * 600)),
    HALF_W'(CLOCK_HZ / (2 * 1100)),  HALF_W'(CLOCK_HZ / (2 * 200)),
    HALF_W'(CLOCK_HZ / (2 * 2550)),  HALF_W'(CLOCK_HZ / (2 * 14000)),
    HALF_W'(CLOCK_HZ / (2 * 1000)),  HALF_W'(CLOCK_HZ / (2 * 150)),
    '0, '0
  };

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(DEFAULT_COUNT);

endpackage

[hw/rtl/tsp_item_if.sv]
// ---------------------------------------------------------------------------
// Tone sequence player item channel
// Valid/ready channel carrying one command beat into the player.
// ---------------------------------------------------------------------------
interface tsp_item_if import tsp_pkg::*; ();
  logic        valid;
  logic        ready;
  action_t     action;
  logic [7:0]  tone_slot;
  logic [15:0] frequency_hz;

  modport source (output valid, output action, output tone_slot, output frequency_hz,
                  input ready);
  modport sink (input valid, input action, input tone_slot, input frequency_hz,
                output ready);
endinterface

[hw/rtl/tsp_result_if.sv]
// ---------------------------------------------------------------------------
// Tone sequence player result channel
// Valid/ready channel carrying one status beat out of the player.
// ---------------------------------------------------------------------------
interface tsp_result_if import tsp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       pin_level;
  err_t       error;
  logic       sounding;
  logic [7:0] tone_index;

  modport source (output valid, output pin_level, output error, output sounding,
                  output tone_index, input ready);
  modport sink (input valid, input pin_level, input error, input sounding,
                input tone_index, output ready);
endinterface

[hw/rtl/tone_sequence_player.sv]
// ---------------------------------------------------------------------------
// Tone sequence player
// Square-wave melody player with a half-period table in a synchronous RAM.
// ---------------------------------------------------------------------------
//   Channel   Dir  Beat contents
//   item      in   action, tone_slot, frequency_hz
//   result    out  pin_level, error, sounding, tone_index (one per item)
//   cfg       in   ticks_per_tone, written when cfg_write is high
//
// Tick, play, stop and rejected writes are answered in the idle state. After a
// play, a tone step or a table write the RAM read port's next-tone prefetch is
// stale, and item.ready stays low until it is refreshed. A valid write runs
// the 25-step serial divider, then commits once the result side is free.
// Reset is synchronous; the table is served from per-slot valid bits, so no
// clearing pass is needed. A stalled result holds the item side off.
// ---------------------------------------------------------------------------
module tone_sequence_player import tsp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [31:0]  cfg_data,
  tsp_item_if.sink     item,
  tsp_result_if.source result
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]        state;
  logic [31:0]       ticks_per_tone;
  logic [LEN_W-1:0]  seq_len;
  logic [SLOT_W-1:0] current_tone;
  logic [31:0]       hold_counter;
  half_t             period_counter;
  half_t             compare_value;
  half_t             slot0_half;
  logic              pin_state;
  logic              timer_en;
  logic              stepping;
  logic              stale;

  logic [SLOT_W-1:0] current_tone_next;
  logic [31:0]       hold_counter_next;
  half_t             period_counter_next;
  half_t             compare_value_next;
  logic              pin_state_next;
  logic              timer_en_next;
  logic              stepping_next;
  logic              tone_step;

  // Table RAM and its per-slot written flags.
  half_t             tone_mem [TONE_SLOTS];
  logic [TONE_SLOTS-1:0] tone_valid;
  logic [SLOT_W-1:0] rd_addr;
  half_t             rd_data;
  half_t             rd_default;
  logic              rd_valid;
  half_t             next_half;
  logic              mem_we;

  // Serial divider.
  logic [SLOT_W-1:0] div_cnt;
  logic [SLOT_W-1:0] div_bit;
  logic [16:0]       div_d;
  logic [16:0]       rem;
  logic [17:0]       rem_sh;
  half_t             quo;
  logic [SLOT_W-1:0] wr_slot;

  logic              res_valid;
  logic              res_pin;
  err_t              res_error;
  logic              res_sounding;
  logic [7:0]        res_index;

  logic              item_accept;
  logic              res_free;
  logic              res_load;
  err_t              wr_err;
  logic [LEN_W-1:0]  tone_inc;
  logic [31:0]       hold_inc;

  assign res_free    = !res_valid || result.ready;
  assign item.ready  = (state == ST_IDLE) && !stale && res_free;
  assign item_accept = item.valid && item.ready;
  assign mem_we      = (state == ST_COMMIT) && res_free;
  // A result beat is loaded for every item except a valid write, whose beat comes on commit.
  assign res_load    = mem_we ||
                       (item_accept && !(item.action == ACT_WRITE && wr_err == ERR_NONE));

  assign result.valid      = res_valid;
  assign result.pin_level  = res_pin;
  assign result.error      = res_error;
  assign result.sounding   = res_sounding;
  assign result.tone_index = res_index;

  always_comb begin
    if (item.tone_slot >= 8'(TONE_SLOTS)) begin
      wr_err = ERR_SLOT;
    end else if (item.frequency_hz == 16'd0) begin
      wr_err = ERR_FREQ;
    end else begin
      wr_err = ERR_NONE;
    end
  end

  // The read port always looks one tone ahead of the one sounding.
  assign rd_addr   = current_tone + SLOT_W'(1);
  assign next_half = rd_valid ? rd_data : rd_default;
  assign tone_inc  = {1'b0, current_tone} + LEN_W'(1);
  assign hold_inc  = hold_counter + 32'd1;

  always_comb begin
    current_tone_next   = current_tone;
    hold_counter_next   = hold_counter;
    period_counter_next = period_counter;
    compare_value_next  = compare_value;
    pin_state_next      = pin_state;
    timer_en_next       = timer_en;
    stepping_next       = stepping;
    tone_step           = 1'b0;
    if (item_accept) begin
      case (item.action)
        ACT_TICK: begin
          if (timer_en) begin
            if (period_counter >= compare_value) begin
              pin_state_next      = !pin_state;
              period_counter_next = '0;
            end else begin
              period_counter_next = period_counter + HALF_W'(1);
            end
            if (stepping) begin
              if (hold_inc >= ticks_per_tone) begin
                hold_counter_next = '0;
                if (tone_inc < seq_len) begin
                  current_tone_next  = rd_addr;
                  compare_value_next = next_half;
                  tone_step          = 1'b1;
                end else begin
                  stepping_next = 1'b0;
                end
              end else begin
                hold_counter_next = hold_inc;
              end
            end
          end
        end
        ACT_PLAY: begin
          timer_en_next       = 1'b1;
          current_tone_next   = '0;
          hold_counter_next   = '0;
          period_counter_next = '0;
          if (seq_len != '0) begin
            compare_value_next = slot0_half;
            stepping_next      = 1'b1;
          end else begin
            stepping_next = 1'b0;
          end
        end
        ACT_STOP: begin
          timer_en_next  = 1'b0;
          stepping_next  = 1'b0;
          pin_state_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign div_bit = SLOT_W'(HALF_W - 1) - div_cnt;
  assign rem_sh  = {rem, CLK_DIVIDEND[div_bit]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tone_mem[wr_slot] <= quo;
    end
    rd_data    <= tone_mem[rd_addr];
    rd_default <= DEFAULT_HALF[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      ticks_per_tone <= TICKS_RESET;
      seq_len        <= LEN_RESET;
      current_tone   <= '0;
      hold_counter   <= '0;
      period_counter <= '0;
      compare_value  <= DEFAULT_HALF[0];
      slot0_half     <= DEFAULT_HALF[0];
      pin_state      <= 1'b0;
      timer_en       <= 1'b0;
      stepping       <= 1'b0;
      stale          <= 1'b1;
      tone_valid     <= '0;
      rd_valid       <= 1'b0;
      res_valid      <= 1'b0;
      div_cnt        <= '0;
    end else begin
      if (cfg_write) begin
        ticks_per_tone <= cfg_data;
      end
      current_tone   <= current_tone_next;
      hold_counter   <= hold_counter_next;
      period_counter <= period_counter_next;
      compare_value  <= compare_value_next;
      pin_state      <= pin_state_next;
      timer_en       <= timer_en_next;
      stepping       <= stepping_next;
      rd_valid       <= tone_valid[rd_addr];
      stale          <= mem_we || tone_step || (item_accept && item.action == ACT_PLAY);

      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (item_accept) begin
            if (item.action == ACT_WRITE && wr_err == ERR_NONE) begin
              state   <= ST_DIV;
              div_d   <= {item.frequency_hz, 1'b0};
              rem     <= '0;
              quo     <= '0;
              div_cnt <= '0;
              wr_slot <= item.tone_slot[SLOT_W-1:0];
            end else begin
              res_pin      <= pin_state_next;
              res_error    <= (item.action == ACT_WRITE) ? wr_err : ERR_NONE;
              res_sounding <= timer_en_next;
              res_index    <= {3'b000, current_tone_next};
            end
          end
        end
        ST_DIV: begin
          // One quotient bit per cycle, restoring form.
          if (rem_sh >= {1'b0, div_d}) begin
            rem <= 17'(rem_sh - {1'b0, div_d});
            quo <= {quo[HALF_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[16:0];
            quo <= {quo[HALF_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + SLOT_W'(1);
          if (div_cnt == SLOT_W'(HALF_W - 1)) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (res_free) begin
            state               <= ST_IDLE;
            tone_valid[wr_slot] <= 1'b1;
            seq_len             <= {1'b0, wr_slot} + LEN_W'(1);
            if (wr_slot == '0) begin
              slot0_half <= quo;
            end
            res_pin      <= pin_state;
            res_error    <= ERR_NONE;
            res_sounding <= timer_en;
            res_index    <= {3'b000, current_tone};
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "tone_sequence_player_macros.svh"

  `TSP_ASSERT(a_step_needs_timer, stepping |-> timer_en, "stepping without timer enabled")
  `TSP_ASSERT(a_stop_silences, (item_accept && item.action == ACT_STOP) |=> !pin_state, "pin high after stop")
  `TSP_ASSERT(a_tone_moves, !$stable(current_tone) |-> (current_tone == $past(current_tone) + SLOT_W'(1) || current_tone == '0), "tone index jumped")

endmodule
